FILE: hdl/assert_macros.svh
// Assertion macros for the RTL; gbk_seq.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while the block is out of reset.
`define GBK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a condition on the cycle after reset is held low.
`define GBK_ASSERT_RST(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> (cond)) else $error(msg);

`endif

FILE: hdl/gbk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbk_pkg;

    localparam int KEY_WORD_W = 64;
    localparam int KEY_FULL_W = 256;
    localparam int COUNT_W    = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  load;
        logic [KEY_FULL_W-1:0] key;
        logic [COUNT_W-1:0]    count;
        logic                  last;
        logic                  ovf;
    } t_emit;

endpackage

`default_nettype wire

FILE: hdl/gbk_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gbk_in_if
    import gbk_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [KEY_WORD_W-1:0] key_word0;
    logic [KEY_WORD_W-1:0] key_word1;
    logic [KEY_WORD_W-1:0] key_word2;
    logic [KEY_WORD_W-1:0] key_word3;
    logic                  set_end;

    modport source (
        output valid, key_word0, key_word1, key_word2, key_word3, set_end,
        input  ready
    );
    modport sink (
        input  valid, key_word0, key_word1, key_word2, key_word3, set_end,
        output ready
    );
endinterface

interface gbk_out_if
    import gbk_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [KEY_WORD_W-1:0] out_word0;
    logic [KEY_WORD_W-1:0] out_word1;
    logic [KEY_WORD_W-1:0] out_word2;
    logic [KEY_WORD_W-1:0] out_word3;
    logic [COUNT_W-1:0]    match_count;
    logic                  run_last;
    logic                  overflowed;

    modport source (
        output valid, out_word0, out_word1, out_word2, out_word3,
               match_count, run_last, overflowed,
        input  ready
    );
    modport sink (
        input  valid, out_word0, out_word1, out_word2, out_word3,
               match_count, run_last, overflowed,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/gbk_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gbk_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/gbk_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gbk_seq
    import gbk_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BYTES   = 32,
    parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int DATA_W      = 8 * KEY_BYTES + COUNT_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gbk_in_if.sink                 i_in,
    output logic                   o_we,
    output logic      [ADDR_W-1:0] o_waddr,
    output logic      [DATA_W-1:0] o_wdata,
    output logic      [ADDR_W-1:0] o_raddr,
    input  wire logic [DATA_W-1:0] i_rdata,
    input  wire logic              i_out_free,
    output t_emit                  o_emit
);

    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int USED_W    = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_MAX = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [USED_W-1:0]   r_used, n_used;
    logic                r_ovf, n_ovf;
    logic                r_end, n_end;
    logic [KEY_W-1:0]    r_key, n_key;

    logic [KEY_FULL_W-1:0] in_full;
    logic [KEY_FULL_W-1:0] rd_full;
    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_W-1:0]    rd_cnt;
    logic [COUNT_W-1:0]    cnt_inc;
    logic                  hit;
    logic                  last_entry;

    assign in_full    = {i_in.key_word3, i_in.key_word2, i_in.key_word1, i_in.key_word0};
    assign rd_key     = i_rdata[DATA_W-1:COUNT_W];
    assign rd_cnt     = i_rdata[COUNT_W-1:0];
    assign hit        = (rd_key == r_key);
    assign last_entry = ((USED_W'(r_idx) + USED_W'(1)) == r_used);
    assign cnt_inc    = (rd_cnt < COUNT_W'(COUNT_MAX)) ? rd_cnt + COUNT_W'(1) : rd_cnt;

    always_comb begin
        rd_full              = '0;
        rd_full[KEY_W-1:0]   = rd_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_used  <= '0;
            r_ovf   <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_used  <= n_used;
            r_ovf   <= n_ovf;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_used        = r_used;
        n_ovf         = r_ovf;
        n_end         = r_end;
        n_key         = r_key;
        i_in.ready    = 1'b0;
        o_we          = 1'b0;
        o_waddr       = r_idx;
        o_wdata       = {r_key, COUNT_W'(1)};
        o_emit        = '0;
        o_emit.key    = rd_full;
        o_emit.count  = rd_cnt;
        o_emit.last   = last_entry;
        o_emit.ovf    = r_ovf;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                n_idx      = '0;
                if (i_in.valid) begin
                    n_key   = in_full[KEY_W-1:0];
                    n_end   = i_in.set_end;
                    n_state = (r_used == '0) ? S_INSERT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    o_we    = 1'b1;
                    o_waddr = r_idx;
                    o_wdata = {r_key, cnt_inc};
                    n_idx   = '0;
                    n_state = r_end ? S_EMIT_RD : S_IDLE;
                end else if (last_entry) begin
                    n_state = S_INSERT;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            S_INSERT: begin
                if (r_used < USED_W'(TABLE_DEPTH)) begin
                    o_we    = 1'b1;
                    o_waddr = r_used[ADDR_W-1:0];
                    o_wdata = {r_key, COUNT_W'(1)};
                    n_used  = r_used + USED_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                n_idx   = '0;
                n_state = r_end ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                n_idx   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit.load = 1'b1;
                    if (last_entry) begin
                        n_used  = '0;
                        n_ovf   = 1'b0;
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The read address leads the index so that data for r_idx is ready in the next cycle.
    assign o_raddr = n_idx;

    `GBK_ASSERT(a_insert_grows, i_clk, i_rst_n, (r_state == S_INSERT && o_we) |=> r_used == USED_W'($past(r_used) + USED_W'(1)), "table fill did not grow on insert")
    `GBK_ASSERT(a_ovf_when_full, i_clk, i_rst_n, $rose(r_ovf) |-> $past(r_used) == USED_W'(TABLE_DEPTH), "overflow set while table not full")
    `GBK_ASSERT(a_last_clears, i_clk, i_rst_n, (o_emit.load && o_emit.last) |=> (r_used == '0 && !r_ovf), "table not cleared after final result")
    `GBK_ASSERT_RST(a_reset_empty, i_clk, i_rst_n, r_used == '0 && r_state == S_IDLE, "table not empty after reset")

endmodule

`default_nettype wire

FILE: hdl/gbk_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module gbk_out_stage
    import gbk_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_emit     i_emit,
    output logic      o_free,
    gbk_out_if.source o_out
);

    logic                  r_valid;
    logic [KEY_FULL_W-1:0] r_key;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_last;
    logic                  r_ovf;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.load) begin
            r_key   <= i_emit.key;
            r_count <= i_emit.count;
            r_last  <= i_emit.last;
            r_ovf   <= i_emit.ovf;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_word0   = r_key[KEY_WORD_W-1:0];
    assign o_out.out_word1   = r_key[2*KEY_WORD_W-1:KEY_WORD_W];
    assign o_out.out_word2   = r_key[3*KEY_WORD_W-1:2*KEY_WORD_W];
    assign o_out.out_word3   = r_key[4*KEY_WORD_W-1:3*KEY_WORD_W];
    assign o_out.match_count = r_count;
    assign o_out.run_last    = r_last;
    assign o_out.overflowed  = r_ovf;

endmodule

`default_nettype wire

FILE: hdl/group_by_key_count.sv
// A record goes straight to insertion when the table is empty; otherwise the stored keys
// are compared one at a time through the single table read port.
// Throughput: one record at a time; after a set_end record's update, a read-setup state
// starts emission, and then results leave at one per cycle while the output side takes them.
// Reset is synchronous and active low; it empties the table and clears the overflow mark,
// and the table memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module group_by_key_count
    import gbk_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BYTES   = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gbk_in_if.sink    i_in,
    gbk_out_if.source o_out
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DATA_W = 8 * KEY_BYTES + COUNT_W;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [DATA_W-1:0] rdata;
    logic              out_free;
    t_emit             emit;

    gbk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    gbk_seq #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_BYTES  (KEY_BYTES),
        .ADDR_W     (ADDR_W),
        .DATA_W     (DATA_W)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .i_out_free(out_free),
        .o_emit    (emit)
    );

    gbk_out_stage u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_emit (emit),
        .o_free (out_free),
        .o_out  (o_out)
    );

endmodule

`default_nettype wire
